// ===== hdl/flow_controlled_byte_fifo_core_macros.svh =====
// Assertion macros shared by the checker of the byte FIFO core.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FLOW_CONTROLLED_BYTE_FIFO_CORE_MACROS_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbf assertion failed");

// Next-cycle implication, disabled during reset.
`define RBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbf assertion failed");

`endif

// ===== hdl/rbf_pkg.sv =====
// Shared types and constants of the byte FIFO core.
// No dependencies; imported by every module of the block.
`default_nettype none

package rbf_pkg;

  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 7;
  localparam int TOT_W         = 32;
  localparam int CMD_W         = 2;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [CMD_W-1:0] {
    OP_WRITE = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  count;
    logic              count_zero;
  } job_t;

  typedef struct packed {
    logic              accepted;
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [CNT_W-1:0]  fill_level;
    logic [TOT_W-1:0]  written_total;
    logic [TOT_W-1:0]  read_total;
    logic              ended;
    logic              end_of_stream;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/rbf_front.sv =====
// Front end: accepts command transactions, classifies them and queues them.
// Depends on rbf_pkg; feeds rbf_back through a two-entry queue.
`default_nettype none

module rbf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rbf_pkg::cmd_t cmd,
  output rbf_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_pop
);
  import rbf_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  job_t       classified;

  assign cmd_stall = (fill == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign job_valid = (fill != 2'd0);
  assign pop       = job_pop && job_valid;
  assign job       = slot[rd_ptr];

  always_comb begin
    classified.op         = op_t'(cmd.command);
    classified.data_byte  = cmd.data_byte;
    classified.count      = cmd.count;
    classified.count_zero = (cmd.count == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rbf_back.sv =====
// Back end: ring memory, pointers, counters and the result register.
// Depends on rbf_pkg; takes jobs from rbf_front and emits result transactions.
`default_nettype none

module rbf_back #(
  parameter int DEPTH = rbf_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rbf_pkg::CNT_W-1:0]  cfg_data,
  input  rbf_pkg::job_t              job,
  input  logic                       job_valid,
  output logic                       job_pop,
  output logic                       res_valid,
  input  logic                       res_stall,
  output rbf_pkg::res_t              res,
  output logic                       busy
);
  import rbf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CNT_W + 1;

  typedef enum logic [1:0] {
    ST_CMD  = 2'b01,
    ST_PEEK = 2'b10
  } state_t;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_q;

  state_t            state;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [CNT_W-1:0]  held;
  logic [TOT_W-1:0]  wr_total;
  logic [TOT_W-1:0]  rd_total;
  logic              ended;
  logic [CW-1:0]     cap;
  logic [AW-1:0]     peek_ptr;
  logic [CNT_W-1:0]  peek_left;

  logic              o_acc;
  logic              o_bv;
  logic              o_last;
  logic [CNT_W-1:0]  o_fill;
  logic [TOT_W-1:0]  o_wt;
  logic [TOT_W-1:0]  o_rt;
  logic              o_ended;
  logic              o_eos;

  logic [AW-1:0]     head_next;
  logic [AW-1:0]     tail_next;
  logic [CNT_W-1:0]  held_next;
  logic [TOT_W-1:0]  wr_total_next;
  logic [TOT_W-1:0]  rd_total_next;
  logic              ended_next;

  logic              load;
  logic              take;
  logic [CNT_W-1:0]  cap_ext;
  logic [CNT_W-1:0]  n;
  logic              room;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [SW-1:0]     pop_sum;
  logic [AW-1:0]     head_pop;
  logic              peek_start;
  logic              peek_step;
  logic              produce;
  logic              last_now;
  logic [CW-1:0]     cap_cfg;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(1);
    return (s == (AW+1)'(c)) ? '0 : s[AW-1:0];
  endfunction

  assign load       = !res_valid || !res_stall;
  assign take       = (state == ST_CMD) && job_valid && load;
  assign job_pop    = take;
  assign cap_ext    = CNT_W'(cap);
  assign n          = (job.count < held) ? job.count : held;
  assign room       = (held < cap_ext);
  assign wr_en      = take && (job.op == OP_WRITE) && room;
  assign peek_start = take && (job.op == OP_PEEK) && !job.count_zero && (held != '0);
  assign peek_step  = (state == ST_PEEK) && load;
  assign produce    = take || peek_step;
  assign rd_en      = peek_start || peek_step;
  assign rd_addr    = (state == ST_PEEK) ? peek_ptr : head;
  assign last_now   = peek_step ? (peek_left == CNT_W'(1)) :
                      (!peek_start || (n == CNT_W'(1)));
  assign busy       = res_valid || (state != ST_CMD);

  assign pop_sum  = SW'(head) + SW'(n);
  assign head_pop = (pop_sum >= SW'(cap)) ? AW'(pop_sum - SW'(cap)) : AW'(pop_sum);

  always_comb begin
    priority if (cfg_data == '0) begin
      cap_cfg = CW'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_cfg = CW'(DEPTH);
    end else begin
      cap_cfg = CW'(cfg_data);
    end
  end

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    held_next     = held;
    wr_total_next = wr_total;
    rd_total_next = rd_total;
    ended_next    = ended;
    if (take) begin
      unique case (job.op)
        OP_WRITE: begin
          if (room) begin
            tail_next     = ring_inc(tail, cap);
            held_next     = held + CNT_W'(1);
            wr_total_next = wr_total + TOT_W'(1);
          end
        end
        OP_POP: begin
          head_next     = head_pop;
          held_next     = held - n;
          rd_total_next = rd_total + TOT_W'(n);
        end
        OP_PEEK: begin
        end
        OP_END: begin
          ended_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CW'(DEPTH);
    end else if (cfg_we) begin
      cap <= cap_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state     <= ST_CMD;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      wr_total  <= '0;
      rd_total  <= '0;
      ended     <= 1'b0;
      peek_ptr  <= '0;
      peek_left <= '0;
      res_valid <= 1'b0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      held     <= held_next;
      wr_total <= wr_total_next;
      rd_total <= rd_total_next;
      ended    <= ended_next;
      if (peek_start) begin
        peek_ptr  <= ring_inc(head, cap);
        peek_left <= n - CNT_W'(1);
        if (n != CNT_W'(1)) begin
          state <= ST_PEEK;
        end
      end else if (peek_step) begin
        peek_ptr  <= ring_inc(peek_ptr, cap);
        peek_left <= peek_left - CNT_W'(1);
        if (peek_left == CNT_W'(1)) begin
          state <= ST_CMD;
        end
      end
      if (load) begin
        res_valid <= produce;
      end
    end
  end

  // hold result fields while stalled
  always_ff @(posedge clk) begin
    if (load && produce) begin
      o_acc   <= wr_en;
      o_bv    <= rd_en;
      o_last  <= last_now;
      o_fill  <= held_next;
      o_wt    <= wr_total_next;
      o_rt    <= rd_total_next;
      o_ended <= ended_next;
      o_eos   <= ended_next && (held_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= job.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    res.accepted      = o_acc;
    res.byte_valid    = o_bv;
    res.out_byte      = o_bv ? rd_q : '0;
    res.last          = o_last;
    res.fill_level    = o_fill;
    res.written_total = o_wt;
    res.read_total    = o_rt;
    res.ended         = o_ended;
    res.end_of_stream = o_eos;
  end

endmodule

`default_nettype wire

// ===== hdl/flow_controlled_byte_fifo_core.sv =====
// Top level of the byte ring-buffer FIFO core.
// Depends on rbf_pkg, rbf_front and rbf_back.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one command per transaction:
//     write byte, pop count bytes, peek count bytes, end input.
//   res channel (res_valid / res_stall / res): write, pop and end input give
//     one result; a peek gives one result per held byte it covers (at least
//     one), last marking the final one. Every result carries fill level, both
//     running totals, the ended flag and end of stream.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): sets the ring capacity and
//     restarts the stream. cfg_ready is high only while the block is idle.
// Flow: an accepted command first fills a queue slot; its first result is loaded
//   into the result register when rbf_back takes it from the queue. Throughput:
//   one result per cycle while res_stall is low; writes and pops stream at one per
//   cycle, a peek of n bytes gives all n results before the next command is taken,
//   each byte read from the ring memory in the cycle its result register loads.
// Reset: empties the queue, clears pointers, counters and the ended flag, and
//   sets the capacity to DEPTH. Memory contents are not cleared.
// res_stall holds the result register; the two-entry command queue then fills
//   and raises cmd_stall.
`default_nettype none

module flow_controlled_byte_fifo_core #(
  parameter int DEPTH = rbf_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  rbf_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_stall,
  output rbf_pkg::res_t              res,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rbf_pkg::CNT_W-1:0]  cfg_data
);
  import rbf_pkg::*;

  job_t  job;
  logic  job_valid;
  logic  job_pop;
  logic  busy;
  logic  cfg_we;

  assign cfg_ready = !job_valid && !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  rbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  rbf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .busy      (busy)
  );

endmodule

`default_nettype wire

// ===== hdl/rbf_checker.sv =====
// Port-level checker of the byte FIFO core, bound to the top level.
// Depends on rbf_pkg and flow_controlled_byte_fifo_core_macros.svh.
`default_nettype none
`include "flow_controlled_byte_fifo_core_macros.svh"

module rbf_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_stall,
  input rbf_pkg::res_t res,
  input logic          cfg_ready
);
  import rbf_pkg::*;

  logic eos_ok;

  assign eos_ok = (res.end_of_stream == (res.ended && (res.fill_level == '0)));

  `RBF_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)
  `RBF_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(res))
  `RBF_ASSERT_IMP(a_eos, clk, rst, res_valid, eos_ok)
  `RBF_ASSERT_IMP(a_peek_only, clk, rst, res_valid && res.byte_valid, !res.accepted)
  `RBF_ASSERT_IMP(a_cfg_idle, clk, rst, res_valid, !cfg_ready)

endmodule

bind flow_controlled_byte_fifo_core rbf_checker u_rbf_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
